[src/line_pixel_generator_macros.svh]
// assertion helpers shared by the line pixel generator modules
`ifndef LINE_PIXEL_GENERATOR_MACROS_SVH
`define LINE_PIXEL_GENERATOR_MACROS_SVH

// property that must hold at every clock edge outside reset
`define LPG_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define LPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lpg_pkg.sv]
package lpg_pkg;

    // coordinate width and result limit
    localparam int COORD_BITS   = 6;
    localparam int MAX_RESULTS  = 62;
    localparam int CNT_BITS     = $clog2(MAX_RESULTS + 1);
    localparam int ERR_BITS     = COORD_BITS + 2;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;
    localparam int M_TDATA_BITS = ((2 * COORD_BITS + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] t_coord;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic step;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic final_step;
        logic out_free;
    } t_stat;

endpackage

[src/line_pixel_generator.sv]
// channel   dir  signals                          payload (lowest bit up)
// request   in   i_s_tvalid/o_s_tready/i_s_tdata  start_x, end_x, start_y, end_y
// pixel     out  o_m_tvalid/i_m_tready/o_m_tdata  pixel_x, pixel_y; o_m_tlast = last_pixel
//
// a request is taken on its handshake, then the walker moves one major-axis position
// per cycle while the output stage can take a pixel, using the single bresenham step unit.
// the next request is taken the cycle after the last step.
// a pixel that waits on i_m_tready freezes the walker; no pixels are lost.
// synchronous active-low reset returns the controller to idle and empties the output stage.
module line_pixel_generator
    import lpg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_s_tvalid,
    output logic                    o_s_tready,
    // start_x, end_x, start_y, end_y
    input  logic [S_TDATA_BITS-1:0] i_s_tdata,
    output logic                    o_m_tvalid,
    input  logic                    i_m_tready,
    // pixel_x, pixel_y, zero pad
    output logic [M_TDATA_BITS-1:0] o_m_tdata,
    output logic                    o_m_tlast
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequencer
    lpg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // line walker and output stage
    lpg_datapath u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

[src/lpg_ctrl.sv]
module lpg_ctrl
    import lpg_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_tvalid,
    output logic  o_s_tready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic {
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (i_stat.out_free && i_stat.final_step) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands and request handshake
    assign o_s_tready = (r_state == ST_IDLE);
    assign o_cmd.load = (r_state == ST_IDLE) && i_s_tvalid;
    assign o_cmd.step = (r_state == ST_WALK) && i_stat.out_free;

endmodule

[src/lpg_datapath.sv]
module lpg_datapath
    import lpg_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    output t_stat                   o_stat,
    input  logic [S_TDATA_BITS-1:0] i_s_tdata,
    input  logic                    i_m_tready,
    output logic                    o_m_tvalid,
    output logic [M_TDATA_BITS-1:0] o_m_tdata,
    output logic                    o_m_tlast
);

    `include "line_pixel_generator_macros.svh"

    // endpoint fields of the incoming request
    t_coord l_sx, l_ex, l_sy, l_ey;
    t_coord l_dx, l_dy;
    t_coord l_a0, l_a1, l_b0, l_b1;
    t_coord l_p0, l_p1, l_q0, l_q1;
    t_coord l_dmaj, l_dmin;
    logic   l_steep;

    // walker state
    t_coord                      r_p, r_q, r_p1, r_q0, r_q1, r_dmaj, r_dmin;
    logic signed [ERR_BITS-1:0]  r_err;
    logic                        r_steep, r_qdir, r_first;
    logic [CNT_BITS-1:0]         r_count;

    // output stage
    logic   r_out_valid, r_out_last;
    t_coord r_px, r_py;

    // step logic
    logic signed [ERR_BITS-1:0]  l_err_sum, l_err_next;
    logic                        l_q_move, l_at_end, l_plot, l_last;
    logic                        l_q_on_line;
    t_coord                      l_q_next;
    logic [COORD_BITS:0]         l_p_inc;

    // line setup from the request
    always_comb begin
        l_sx    = i_s_tdata[COORD_BITS-1:0];
        l_ex    = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
        l_sy    = i_s_tdata[3*COORD_BITS-1:2*COORD_BITS];
        l_ey    = i_s_tdata[4*COORD_BITS-1:3*COORD_BITS];
        l_dx    = (l_ex > l_sx) ? (l_ex - l_sx) : (l_sx - l_ex);
        l_dy    = (l_ey > l_sy) ? (l_ey - l_sy) : (l_sy - l_ey);
        l_steep = (l_dy > l_dx);
        l_a0    = l_steep ? l_sy : l_sx;
        l_a1    = l_steep ? l_ey : l_ex;
        l_b0    = l_steep ? l_sx : l_sy;
        l_b1    = l_steep ? l_ex : l_ey;
        // order so the major coordinate rises
        if (l_a0 > l_a1) begin
            l_p0 = l_a1;
            l_p1 = l_a0;
            l_q0 = l_b1;
            l_q1 = l_b0;
        end else begin
            l_p0 = l_a0;
            l_p1 = l_a1;
            l_q0 = l_b0;
            l_q1 = l_b1;
        end
        l_dmaj = l_p1 - l_p0;
        l_dmin = (l_q1 > l_q0) ? (l_q1 - l_q0) : (l_q0 - l_q1);
    end

    // one bresenham step along the major axis
    always_comb begin
        l_err_sum  = r_err + $signed({2'b00, r_dmin});
        l_q_move   = (l_err_sum > 0);
        l_err_next = l_q_move ? (l_err_sum - $signed({2'b00, r_dmaj})) : l_err_sum;
        l_q_next   = l_q_move ? (r_qdir ? (r_q + 1'b1) : (r_q - 1'b1)) : r_q;
        l_p_inc    = {1'b0, r_p} + 1'b1;
        l_at_end   = (r_p == r_p1) && (r_q == r_q1);
        l_plot     = !r_first && !l_at_end && (r_count < CNT_BITS'(MAX_RESULTS));
        // last when nothing can be plotted after this step
        l_last     = (r_p == r_p1)
                   || ((l_p_inc == {1'b0, r_p1}) && (l_q_next == r_q1))
                   || (r_count == CNT_BITS'(MAX_RESULTS - 1));
        // minor coordinate still between its endpoints
        l_q_on_line = r_qdir ? (r_q >= r_q0 && r_q <= r_q1)
                             : (r_q <= r_q0 && r_q >= r_q1);
    end

    // walker registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p     <= l_p0;
            r_q     <= l_q0;
            r_p1    <= l_p1;
            r_q0    <= l_q0;
            r_q1    <= l_q1;
            r_dmaj  <= l_dmaj;
            r_dmin  <= l_dmin;
            r_err   <= '0 - ERR_BITS'(l_dmaj >> 1);
            r_steep <= l_steep;
            r_qdir  <= (l_q0 < l_q1);
            r_first <= 1'b1;
            r_count <= '0;
        end else if (i_cmd.step) begin
            r_p     <= l_p_inc[COORD_BITS-1:0];
            r_q     <= l_q_next;
            r_err   <= l_err_next;
            r_first <= 1'b0;
            if (l_plot) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    // output stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.step && l_plot) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output stage payload, back in the original orientation
    always_ff @(posedge i_clk) begin
        if (i_cmd.step && l_plot) begin
            r_px       <= r_steep ? r_q : r_p;
            r_py       <= r_steep ? r_p : r_q;
            r_out_last <= l_last;
        end
    end

    always_comb begin
        o_m_tdata                   = '0;
        o_m_tdata[2*COORD_BITS-1:0] = {r_py, r_px};
    end

    assign o_m_tvalid        = r_out_valid;
    assign o_m_tlast         = r_out_last;
    assign o_stat.final_step = (r_p == r_p1);
    assign o_stat.out_free   = !r_out_valid || i_m_tready;

    `LPG_ASSERT(a_step_free, i_cmd.step |-> o_stat.out_free, "step into a full output stage")
    `LPG_ASSERT_NEXT(a_plot_shown, i_cmd.step && l_plot, r_out_valid, "pixel not presented")
    `LPG_ASSERT(a_q_range, i_cmd.step |-> l_q_on_line, "minor coordinate left the line")
    `LPG_ASSERT(a_count_cap, i_cmd.step |-> (r_count <= CNT_BITS'(MAX_RESULTS)), "count over limit")

endmodule

[tb/sv/tb_line_pixel_generator.sv]
module tb_line_pixel_generator;
    import lpg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // n_typed value that hands a row to the line predictor
    localparam int     PREDICT      = -1;
    localparam int     MAX_GAP      = 18;
    localparam int     HOLD_CYCLES  = 300;
    localparam int     DRAIN_CYCLES = 70;
    localparam int     RANDOM_LINES = 100;
    localparam int     MAX_PRINTS   = 50;
    localparam t_coord COORD_MAX    = '1;

    // one line request, with up to two pixels typed in by hand
    typedef struct {
        t_coord sx;
        t_coord ex;
        t_coord sy;
        t_coord ey;
        int     n_typed;
        t_coord x0;
        t_coord y0;
        t_coord x1;
        t_coord y1;
    } t_line_req;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    logic                    i_clk      = 1'b0;
    logic                    i_rst_n    = 1'b0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    // start_x, end_x, start_y, end_y
    logic [S_TDATA_BITS-1:0] i_s_tdata  = '0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    // pixel_x, pixel_y, zero pad
    logic [M_TDATA_BITS-1:0] o_m_tdata;
    logic                    o_m_tlast;

    t_pixel pixel_q[$];
    int     fail_count = 0;
    bit     no_idle    = 1'b0;
    bit     hold_off   = 1'b0;

    // sx, ex, sy, ey, typed pixel count, then typed pixels x0, y0, x1, y1
    t_line_req line_table [20] = '{
        // equal endpoints at both corners
        '{6'd0,  6'd0,  6'd0,  6'd0,  0,       6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd63, 6'd63, 6'd63, 6'd63, 0,       6'd0,  6'd0,  6'd0,  6'd0},
        // adjacent endpoints, straight and diagonal
        '{6'd10, 6'd11, 6'd20, 6'd20, 0,       6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd40, 6'd39, 6'd40, 6'd41, 0,       6'd0,  6'd0,  6'd0,  6'd0},
        // short horizontal, reversed vertical, diagonal at the top corner
        '{6'd0,  6'd3,  6'd0,  6'd0,  2,       6'd1,  6'd0,  6'd2,  6'd0},
        '{6'd0,  6'd0,  6'd63, 6'd60, 2,       6'd0,  6'd61, 6'd0,  6'd62},
        '{6'd63, 6'd61, 6'd63, 6'd61, 1,       6'd62, 6'd62, 6'd0,  6'd0},
        // full-length lines
        '{6'd0,  6'd63, 6'd0,  6'd63, PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd63, 6'd0,  6'd0,  6'd63, PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0,  6'd63, 6'd0,  6'd0,  PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0,  6'd0,  6'd63, 6'd0,  PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        // shallow and steep, both directions
        '{6'd0,  6'd63, 6'd0,  6'd17, PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd5,  6'd0,  6'd63, 6'd0,  PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd63, 6'd2,  6'd10, 6'd11, PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd20, 6'd22, 6'd5,  6'd50, PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        // minor step right after the first plotted pixel
        '{6'd7,  6'd9,  6'd7,  6'd8,  PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd0,  6'd2,  6'd0,  6'd1,  PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd33, 6'd30, 6'd30, 6'd31, PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        // alternating bit patterns
        '{6'd42, 6'd21, 6'd21, 6'd42, PREDICT, 6'd0,  6'd0,  6'd0,  6'd0},
        '{6'd21, 6'd42, 6'd42, 6'd21, PREDICT, 6'd0,  6'd0,  6'd0,  6'd0}
    };

    line_pixel_generator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        if (fail_count < MAX_PRINTS) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        fail_count++;
    endtask

    function automatic int coord_dist(input int a, input int b);
        return (a > b) ? a - b : b - a;
    endfunction

    // bresenham walk along the major axis, endpoints left out
    function automatic void predict_line_pixels(input t_line_req r);
        int     p0, p1, q0, q1, tmp, dmaj, dmin, err, q, qstep;
        bit     steep, at_start;
        t_pixel walk[$];
        steep = coord_dist(r.ey, r.sy) > coord_dist(r.ex, r.sx);
        if (steep) begin
            p0 = r.sy; q0 = r.sx; p1 = r.ey; q1 = r.ex;
        end else begin
            p0 = r.sx; q0 = r.sy; p1 = r.ex; q1 = r.ey;
        end
        if (p0 > p1) begin
            tmp = p0; p0 = p1; p1 = tmp;
            tmp = q0; q0 = q1; q1 = tmp;
        end
        dmaj  = p1 - p0;
        dmin  = coord_dist(q1, q0);
        err   = -(dmaj / 2);
        q     = q0;
        qstep = (q0 < q1) ? 1 : -1;
        for (int p = p0; p <= p1; p++) begin
            if (p == p1 && q == q1) continue;
            at_start = (p == p0) && (q == q0);
            // the start pixel is not plotted but still advances the error
            if (!at_start && walk.size() < MAX_RESULTS) begin
                walk.push_back('{x: t_coord'(steep ? q : p), y: t_coord'(steep ? p : q),
                                 last: 1'b0});
            end
            err += dmin;
            if (err > 0) begin
                q   += qstep;
                err -= dmaj;
            end
        end
        if (walk.size() > 0) begin
            walk[walk.size() - 1].last = 1'b1;
        end
        foreach (walk[i]) pixel_q.push_back(walk[i]);
    endfunction

    // coordinate within span of the given one, clamped to the grid
    function automatic t_coord near_coord(input t_coord c, input int span);
        int v;
        v = int'(c) + $urandom_range(0, 2 * span) - span;
        if (v < 0) v = 0;
        if (v > COORD_MAX) v = COORD_MAX;
        return t_coord'(v);
    endfunction

    // mostly short lines, some full random, some degenerate, some corners
    function automatic t_line_req random_request();
        t_line_req r;
        int        kind;
        r = '{t_coord'($urandom), t_coord'($urandom), t_coord'($urandom),
              t_coord'($urandom), PREDICT, 6'd0, 6'd0, 6'd0, 6'd0};
        kind = $urandom_range(0, 99);
        if (kind >= 25 && kind < 75) begin
            r.ex = near_coord(r.sx, 10);
            r.ey = near_coord(r.sy, 10);
        end else if (kind >= 75 && kind < 90) begin
            r.ex = near_coord(r.sx, 1);
            r.ey = near_coord(r.sy, 1);
        end else if (kind >= 90) begin
            r.sx = $urandom_range(0, 1) ? COORD_MAX : '0;
            r.ex = $urandom_range(0, 1) ? COORD_MAX : '0;
            r.sy = $urandom_range(0, 1) ? COORD_MAX : '0;
            r.ey = $urandom_range(0, 1) ? COORD_MAX : '0;
        end
        return r;
    endfunction

    // offer one request, then queue its pixels once it is taken
    task automatic send_request(input t_line_req r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= S_TDATA_BITS'({r.ey, r.sy, r.ex, r.sx});
        do @(posedge i_clk); while (!(i_s_tvalid && o_s_tready));
        if (r.n_typed == PREDICT) begin
            predict_line_pixels(r);
        end else begin
            if (r.n_typed > 0) pixel_q.push_back('{x: r.x0, y: r.y0, last: r.n_typed == 1});
            if (r.n_typed > 1) pixel_q.push_back('{x: r.x1, y: r.y1, last: 1'b1});
        end
    endtask

    // stop offering until every queued pixel is out and the walker is idle
    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // pixel receiver with random stalls and one long hold-off
    initial begin
        int gap;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
            if (hold_off) begin
                gap      = HOLD_CYCLES;
                hold_off = 1'b0;
            end
            if (gap > 0) begin
                i_m_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!(o_m_tvalid && i_m_tready));
        end
    end

    // compare each pixel with the oldest expected one
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (pixel_q.size() == 0) begin
                report_mismatch($sformatf("unexpected pixel x=%0d y=%0d last=%0b",
                                          o_m_tdata[COORD_BITS-1:0],
                                          o_m_tdata[2*COORD_BITS-1:COORD_BITS], o_m_tlast));
            end else begin
                want = pixel_q.pop_front();
                if (o_m_tdata[COORD_BITS-1:0] !== want.x) begin
                    report_mismatch($sformatf("pixel_x got %0d want %0d",
                                              o_m_tdata[COORD_BITS-1:0], want.x));
                end
                if (o_m_tdata[2*COORD_BITS-1:COORD_BITS] !== want.y) begin
                    report_mismatch($sformatf("pixel_y got %0d want %0d",
                                              o_m_tdata[2*COORD_BITS-1:COORD_BITS], want.y));
                end
                if (o_m_tlast !== want.last) begin
                    report_mismatch($sformatf("last_pixel got %0b want %0b at x=%0d y=%0d",
                                              o_m_tlast, want.last, want.x, want.y));
                end
            end
        end
    end

    // main sequence
    initial begin
        t_line_req r;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines
        foreach (line_table[i]) send_request(line_table[i]);
        wait_drain();

        // receiver holds off while long lines keep coming back to back
        no_idle  = 1'b1;
        hold_off = 1'b1;
        repeat (8) begin
            r    = random_request();
            r.sx = '0;
            r.ex = COORD_MAX;
            send_request(r);
        end
        wait_drain();

        // random lines, every third stretch of twenty without idling
        for (int i = 0; i < RANDOM_LINES; i++) begin
            no_idle = ((i / 20) % 3) == 2;
            send_request(random_request());
        end
        wait_drain();

        if (fail_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // run limit
    initial begin
        #4ms;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/lpg_pkg.sv
src/lpg_ctrl.sv
src/lpg_datapath.sv
src/line_pixel_generator.sv
tb/sv/tb_line_pixel_generator.sv
